// ===== sv/nwc_pkg.sv =====
// nwc_pkg: shared constants, types and helpers of the normalized window convolution
// used by nwc_front, nwc_back and the top module; no dependencies
package nwc_pkg;

    localparam int KERNEL_W_DEF  = 3;
    localparam int KERNEL_H_DEF  = 3;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int MAX_HEIGHT = 4096;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int N_CH       = 3;
    localparam int WT_W       = 7;
    localparam int N_WEIGHTS  = 9;
    localparam int WP_W       = 63;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CC_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int ACC_W      = 19;
    localparam int WSUM_W     = 11;
    localparam int JOB_DEPTH  = 4;
    localparam int RES_DEPTH  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHTS  = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_HEIGHT   = 2'd2,
        CFG_CHANNELS = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch2;
        logic            frame_end;
        logic            zero_weight;
    } result_t;

    localparam int RES_W = $bits(result_t);

    function automatic logic [WT_W-1:0] weight_of(input logic [WP_W-1:0] wp,
                                                  input logic [3:0] k);
        logic [WT_W-1:0] res;
        res = '0;
        for (int i = 0; i < N_WEIGHTS; i++)
        begin
            if (k == 4'(i))
            begin
                res = wp[WT_W*i +: WT_W];
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/nwc_fifo.sv =====
// nwc_fifo: small register queue between front, back and result ports
// depends on nothing
module nwc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ===== sv/nwc_front.sv =====
// nwc_front: accepts items, keeps the raster counters and decides which items emit
// depends on nwc_pkg
module nwc_front
    import nwc_pkg::*;
#(
    parameter int KERNEL_W  = KERNEL_W_DEF,
    parameter int KERNEL_H  = KERNEL_H_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 req_type,
    input  logic [CH_W-1:0]      sample_ch0,
    input  logic [CH_W-1:0]      sample_ch1,
    input  logic [CH_W-1:0]      sample_ch2,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
    input  logic [HGT_W-1:0]     eff_h,
    input  logic                 job_full,
    output logic                 job_push,
    output logic [2*$clog2(2*(KERNEL_H/2)+2)+2*$clog2(MAX_WIDTH)+PIX_W+ROW_W+2:0] job_data
);
    localparam int HALF_W = KERNEL_W / 2;
    localparam int HALF_H = KERNEL_H / 2;
    localparam int SLOTS  = 2 * HALF_H + 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int CI_W   = EW + 1;
    localparam int POS_W  = ROW_W + EW + 1;

    logic [ROW_W-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic              in_done_reg, in_done_next;

    logic              accept, is_pix, wr, emit, last;
    logic [POS_W-1:0]  pos, lag;
    logic [CI_W-1:0]   col_inc, ocol_inc;
    logic [HGT_W-1:0]  row_inc, orow_inc;

    assign full   = job_full;
    assign accept = push && !job_full;
    assign is_pix = !in_done_reg && !req_type;
    assign wr     = is_pix && (CI_W'(in_col_reg) < CI_W'(MAX_WIDTH));

    assign pos  = POS_W'(in_row_reg) * POS_W'(eff_w) + POS_W'(in_col_reg);
    assign lag  = POS_W'(HALF_H) * POS_W'(eff_w) + POS_W'(HALF_W);
    assign emit = in_done_reg || (is_pix && (pos >= lag));

    assign col_inc  = CI_W'(in_col_reg) + 1'b1;
    assign row_inc  = HGT_W'(in_row_reg) + 1'b1;
    assign ocol_inc = CI_W'(out_col_reg) + 1'b1;
    assign orow_inc = HGT_W'(out_row_reg) + 1'b1;
    assign last     = (orow_inc >= eff_h) && (ocol_inc >= CI_W'(eff_w));

    assign job_push = accept && (wr || emit);
    assign job_data = {wr, in_slot_reg, in_col_reg, sample_ch2, sample_ch1, sample_ch0,
                       emit, last, out_slot_reg, out_row_reg, out_col_reg};

    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        in_done_next  = in_done_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        if (accept)
        begin
            if (is_pix)
            begin
                if (col_inc >= CI_W'(eff_w))
                begin
                    in_col_next = '0;
                    if (row_inc >= eff_h)
                    begin
                        in_row_next  = '0;
                        in_slot_next = '0;
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_row_next  = row_inc[ROW_W-1:0];
                        in_slot_next = (in_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                       : in_slot_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_next = col_inc[COL_W-1:0];
                end
            end
            if (emit)
            begin
                if (last)
                begin
                    in_row_next   = '0;
                    in_col_next   = '0;
                    in_slot_next  = '0;
                    in_done_next  = 1'b0;
                    out_row_next  = '0;
                    out_col_next  = '0;
                    out_slot_next = '0;
                end
                else if (ocol_inc >= CI_W'(eff_w))
                begin
                    out_col_next = '0;
                    if (orow_inc >= eff_h)
                    begin
                        out_row_next  = '0;
                        out_slot_next = '0;
                    end
                    else
                    begin
                        out_row_next  = orow_inc[ROW_W-1:0];
                        out_slot_next = (out_slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                        : out_slot_reg + 1'b1;
                    end
                end
                else
                begin
                    out_col_next = ocol_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_done_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            in_done_reg  <= in_done_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
        end
    end
endmodule

// ===== sv/nwc_back.sv =====
// nwc_back: line store, window tap walk, weighted sums and serial division
// depends on nwc_pkg
module nwc_back
    import nwc_pkg::*;
#(
    parameter int KERNEL_W  = KERNEL_W_DEF,
    parameter int KERNEL_H  = KERNEL_H_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_empty,
    input  logic [2*$clog2(2*(KERNEL_H/2)+2)+2*$clog2(MAX_WIDTH)+PIX_W+ROW_W+2:0] job_data,
    output logic                 job_pop,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_w,
    input  logic [HGT_W-1:0]     eff_h,
    input  logic [WP_W-1:0]      weights,
    input  logic [CC_W-1:0]      channel_count,
    input  logic                 res_full,
    output logic                 res_push,
    output result_t              res_data
);
    localparam int HALF_W = KERNEL_W / 2;
    localparam int HALF_H = KERNEL_H / 2;
    localparam int WIN_W  = 2 * HALF_W + 1;
    localparam int WIN_H  = 2 * HALF_H + 1;
    localparam int SLOTS  = 2 * HALF_H + 2;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SS_W   = SLOT_W + 3;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int CS_W   = EW + 2;
    localparam int RS_W   = HGT_W + 1;
    localparam int D_W    = $clog2(WIN_H + 1);
    localparam int X_W    = $clog2(WIN_W + 1);
    localparam int K_W    = 6;
    localparam int CNT_W  = $clog2(ACC_W);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TAPS  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    logic              h_wr, h_emit, h_last;
    logic [SLOT_W-1:0] h_wr_slot, h_out_slot;
    logic [COL_W-1:0]  h_wr_col, h_out_col;
    logic [PIX_W-1:0]  h_pix;
    logic [ROW_W-1:0]  h_out_row;

    assign {h_wr, h_wr_slot, h_wr_col, h_pix, h_emit, h_last, h_out_slot, h_out_row,
            h_out_col} = job_data;

    logic [PIX_W-1:0]  line_mem [SLOTS][MAX_WIDTH];

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              last_reg, last_next;
    logic [D_W-1:0]    dy_reg, dy_next;
    logic [X_W-1:0]    dx_reg, dx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg [N_CH];
    logic [ACC_W-1:0]  acc_next [N_CH];
    logic [WSUM_W-1:0] rem_reg [N_CH];
    logic [WSUM_W-1:0] rem_next [N_CH];
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic              rd_valid_reg;
    logic [WT_W-1:0]   rd_wt_reg;
    logic [PIX_W-1:0]  rd_data_reg;

    logic [RS_W-1:0]   rsum;
    logic [CS_W-1:0]   csum;
    logic              tap_in;
    logic [SS_W-1:0]   s0, s1, s2;
    logic [SLOT_W-1:0] tap_slot;
    logic [COL_W-1:0]  tap_col;
    logic [K_W-1:0]    k;
    logic [WT_W-1:0]   tap_wt;
    logic              wr_en;
    logic [WSUM_W:0]   sh [N_CH];
    logic              ge [N_CH];

    assign rsum   = RS_W'(row_reg) + RS_W'(dy_reg);
    assign csum   = CS_W'(col_reg) + CS_W'(dx_reg);
    assign tap_in = (rsum >= RS_W'(HALF_H)) && (rsum < RS_W'(eff_h) + RS_W'(HALF_H))
                 && (csum >= CS_W'(HALF_W)) && (csum < CS_W'(eff_w) + CS_W'(HALF_W));
    assign tap_col = COL_W'(csum - CS_W'(HALF_W));

    // row slot of the tap, modulo the slot count
    assign s0 = SS_W'(slot_reg) + SS_W'(dy_reg) + SS_W'(SLOTS - HALF_H);
    assign s1 = (s0 >= SS_W'(SLOTS)) ? s0 - SS_W'(SLOTS) : s0;
    assign s2 = (s1 >= SS_W'(SLOTS)) ? s1 - SS_W'(SLOTS) : s1;
    assign tap_slot = s2[SLOT_W-1:0];

    assign k = K_W'(dy_reg) * K_W'(KERNEL_W) + K_W'(dx_reg);
    assign tap_wt = ((D_W'(dy_reg) < D_W'(KERNEL_H)) && (X_W'(dx_reg) < X_W'(KERNEL_W))
                     && (k < K_W'(N_WEIGHTS))) ? weight_of(weights, k[3:0]) : '0;

    assign job_pop = (state_reg == S_IDLE) && !job_empty;
    assign wr_en   = job_pop && h_wr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[h_wr_slot][h_wr_col] <= h_pix;
        end
        if ((state_reg == S_TAPS) && tap_in)
        begin
            rd_data_reg <= line_mem[tap_slot][tap_col];
        end
        rd_wt_reg <= tap_wt;
    end

    always_comb
    begin
        for (int c = 0; c < N_CH; c++)
        begin
            sh[c] = {rem_reg[c], acc_reg[c][ACC_W-1]};
            ge[c] = (sh[c] >= {1'b0, wsum_reg});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        last_next  = last_reg;
        dy_next    = dy_reg;
        dx_next    = dx_reg;
        cnt_next   = cnt_reg;
        wsum_next  = wsum_reg;
        for (int c = 0; c < N_CH; c++)
        begin
            acc_next[c] = acc_reg[c];
            rem_next[c] = rem_reg[c];
        end
        res_push = 1'b0;

        if (rd_valid_reg)
        begin
            wsum_next = wsum_reg + WSUM_W'(rd_wt_reg);
            for (int c = 0; c < N_CH; c++)
            begin
                acc_next[c] = acc_reg[c]
                    + ACC_W'(rd_wt_reg * rd_data_reg[CH_W*c +: CH_W]);
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_pop && h_emit)
                begin
                    state_next = S_TAPS;
                    slot_next  = h_out_slot;
                    row_next   = h_out_row;
                    col_next   = h_out_col;
                    last_next  = h_last;
                    dy_next    = '0;
                    dx_next    = '0;
                    wsum_next  = '0;
                    for (int c = 0; c < N_CH; c++)
                    begin
                        acc_next[c] = '0;
                    end
                end
            end
            S_TAPS:
            begin
                if (dx_reg == X_W'(WIN_W - 1))
                begin
                    dx_next = '0;
                    if (dy_reg == D_W'(WIN_H - 1))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        dy_next = dy_reg + 1'b1;
                    end
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
                for (int c = 0; c < N_CH; c++)
                begin
                    rem_next[c] = '0;
                end
            end
            S_DIV:
            begin
                // restoring divide, one quotient bit per cycle, dividend shifts out of acc
                for (int c = 0; c < N_CH; c++)
                begin
                    rem_next[c] = ge[c] ? WSUM_W'(sh[c] - {1'b0, wsum_reg})
                                        : sh[c][WSUM_W-1:0];
                    acc_next[c] = {acc_reg[c][ACC_W-2:0], ge[c]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_data.ch0 = ((channel_count > CC_W'(0)) && (wsum_reg != '0))
                       ? acc_reg[0][CH_W-1:0] : '0;
        res_data.ch1 = ((channel_count > CC_W'(1)) && (wsum_reg != '0))
                       ? acc_reg[1][CH_W-1:0] : '0;
        res_data.ch2 = ((channel_count > CC_W'(2)) && (wsum_reg != '0))
                       ? acc_reg[2][CH_W-1:0] : '0;
        res_data.frame_end   = last_reg;
        res_data.zero_weight = (wsum_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        last_reg <= last_next;
        wsum_reg <= wsum_next;
        for (int c = 0; c < N_CH; c++)
        begin
            acc_reg[c] <= acc_next[c];
            rem_reg[c] <= rem_next[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            dy_reg       <= '0;
            dx_reg       <= '0;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dy_reg       <= dy_next;
            dx_reg       <= dx_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= (state_reg == S_TAPS) && tap_in;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_drain_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |=> (state_reg == S_DIV) && (cnt_reg == '0))
        else $error("divider not started after the last tap");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(ACC_W)))
        else $error("divider step count out of range");

    a_no_read_outside_taps: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ($past(state_reg) == S_TAPS))
        else $error("tap accumulated outside the tap walk");
endmodule

// ===== sv/normalized_window_convolution.sv =====
// normalized window convolution over a raster pixel stream, config registers on top
// each emitted result passes the back's states: job pop, a tap walk with one line store
// read per cycle, a drain, the bit-serial divider and the output push, which waits while
// the result queue is full; no new item is popped until then, and non-emitting items skip
// the tap walk. reset is asynchronous active low and clears counters and queues; the line
// store is not cleared. depends on nwc_pkg, nwc_fifo, nwc_front, nwc_back
module normalized_window_convolution
    import nwc_pkg::*;
#(
    parameter int KERNEL_W  = KERNEL_W_DEF,
    parameter int KERNEL_H  = KERNEL_H_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 req_type,
    input  logic [CH_W-1:0]      sample_ch0,
    input  logic [CH_W-1:0]      sample_ch1,
    input  logic [CH_W-1:0]      sample_ch2,
    output logic                 empty,
    input  logic                 pop,
    output logic [CH_W-1:0]      filtered_ch0,
    output logic [CH_W-1:0]      filtered_ch1,
    output logic [CH_W-1:0]      filtered_ch2,
    output logic                 frame_end,
    output logic                 zero_weight,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WP_W-1:0]      cfg_data
);
    localparam int SLOT_W = $clog2(2 * (KERNEL_H / 2) + 2);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW     = $clog2(MAX_WIDTH + 1);
    localparam int JOB_W  = 2 * SLOT_W + 2 * COL_W + PIX_W + ROW_W + 3;
    localparam int CW     = (FW_W > EW) ? FW_W : EW;

    logic [WP_W-1:0]  weights_reg;
    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [CC_W-1:0]  channel_count_reg;

    logic [EW-1:0]    eff_w;
    logic [HGT_W-1:0] eff_h;
    logic [CW-1:0]    fw_x;

    logic             job_push, job_full, job_pop, job_empty;
    logic [JOB_W-1:0] job_in, job_out;
    logic             res_push, res_full;
    result_t          res_in, res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg       <= '0;
            frame_width_reg   <= FW_W'(1024);
            frame_height_reg  <= FH_W'(1024);
            channel_count_reg <= CC_W'(3);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_WEIGHTS:  weights_reg       <= cfg_data;
                CFG_WIDTH:    frame_width_reg   <= cfg_data[FW_W-1:0];
                CFG_HEIGHT:   frame_height_reg  <= cfg_data[FH_W-1:0];
                CFG_CHANNELS: channel_count_reg <= cfg_data[CC_W-1:0];
                default:      ;
            endcase
        end
    end

    // zero means one, and the sizes clamp to the line store and the row counter
    assign fw_x  = CW'(frame_width_reg);
    assign eff_w = (fw_x == '0) ? EW'(1)
                 : (fw_x > CW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(fw_x);
    assign eff_h = (frame_height_reg == '0) ? HGT_W'(1)
                 : (frame_height_reg > FH_W'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT)
                 : HGT_W'(frame_height_reg);

    nwc_front #(
        .KERNEL_W  (KERNEL_W),
        .KERNEL_H  (KERNEL_H),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .sample_ch0 (sample_ch0),
        .sample_ch1 (sample_ch1),
        .sample_ch2 (sample_ch2),
        .eff_w      (eff_w),
        .eff_h      (eff_h),
        .job_full   (job_full),
        .job_push   (job_push),
        .job_data   (job_in)
    );

    nwc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_out),
        .empty (job_empty)
    );

    nwc_back #(
        .KERNEL_W  (KERNEL_W),
        .KERNEL_H  (KERNEL_H),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_empty     (job_empty),
        .job_data      (job_out),
        .job_pop       (job_pop),
        .eff_w         (eff_w),
        .eff_h         (eff_h),
        .weights       (weights_reg),
        .channel_count (channel_count_reg),
        .res_full      (res_full),
        .res_push      (res_push),
        .res_data      (res_in)
    );

    nwc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign filtered_ch0 = res_out.ch0;
    assign filtered_ch1 = res_out.ch1;
    assign filtered_ch2 = res_out.ch2;
    assign frame_end    = res_out.frame_end;
    assign zero_weight  = res_out.zero_weight;
endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for normalized_window_convolution, random frames and flushes
// checks results against a cycle-free predictor of the 3x3 normalized window
// depends on nwc_pkg and the normalized_window_convolution rtl
`timescale 1ns / 1ps

module tb;
    import nwc_pkg::*;

    typedef struct {
        logic            flush;
        logic [CH_W-1:0] s0;
        logic [CH_W-1:0] s1;
        logic [CH_W-1:0] s2;
    } pixel_item_t;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic                 req_type;
    logic [CH_W-1:0]      sample_ch0;
    logic [CH_W-1:0]      sample_ch1;
    logic [CH_W-1:0]      sample_ch2;
    logic                 empty;
    logic                 pop;
    logic [CH_W-1:0]      filtered_ch0;
    logic [CH_W-1:0]      filtered_ch1;
    logic [CH_W-1:0]      filtered_ch2;
    logic                 frame_end;
    logic                 zero_weight;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WP_W-1:0]      cfg_data;

    normalized_window_convolution dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req_type(req_type),
        .sample_ch0(sample_ch0), .sample_ch1(sample_ch1), .sample_ch2(sample_ch2),
        .empty(empty), .pop(pop), .filtered_ch0(filtered_ch0),
        .filtered_ch1(filtered_ch1), .filtered_ch2(filtered_ch2),
        .frame_end(frame_end), .zero_weight(zero_weight), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [WP_W-1:0] cur_weights;
    logic [FW_W-1:0] cur_width;
    logic [FH_W-1:0] cur_height;
    logic [CC_W-1:0] cur_channels;
    logic [PIX_W-1:0] row_mem [4][MAX_WIDTH_DEF];
    int unsigned in_row, in_col, out_row, out_col;
    bit frame_in_done;

    pixel_item_t pending_items[$];
    result_t     expected_pixels[$];
    int          n_accepted;
    bit          failed;
    bit          tx_burst, rx_burst;
    int          tx_gap, rx_gap, rx_stall;
    bit          stall_used;

    function automatic int unsigned width_eff();
        if (cur_width == 0) return 1;
        if (cur_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return cur_width;
    endfunction

    function automatic int unsigned height_eff();
        if (cur_height == 0) return 1;
        if (cur_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cur_height;
    endfunction

    function automatic void predict_pixel(pixel_item_t it);
        int unsigned w, h, pos, wsum, wt;
        int unsigned acc [3];
        int rr, cc;
        logic [PIX_W-1:0] pix;
        bit emit;
        bit last;
        result_t r;
        w = width_eff();
        h = height_eff();
        emit = 0;
        if (!frame_in_done) begin
            if (it.flush) return;
            row_mem[in_row % 4][in_col] = {it.s2, it.s1, it.s0};
            pos = in_row * w + in_col;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h)
                begin
                    in_row = 0;
                    frame_in_done = 1;
                end
            end
            emit = (pos >= w + 1);
        end
        else
            emit = 1;
        if (!emit) return;
        wsum = 0;
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int dy = 0; dy < 3; dy++)
        begin
            for (int dx = 0; dx < 3; dx++)
            begin
                rr = int'(out_row) + dy - 1;
                cc = int'(out_col) + dx - 1;
                if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
                pix = row_mem[rr % 4][cc];
                wt = cur_weights[WT_W*(dy*3+dx) +: WT_W];
                wsum += wt;
                for (int c = 0; c < 3; c++) acc[c] += wt * pix[8*c +: 8];
            end
        end
        r.ch0 = (cur_channels > 0 && wsum != 0) ? 8'(acc[0] / wsum) : '0;
        r.ch1 = (cur_channels > 1 && wsum != 0) ? 8'(acc[1] / wsum) : '0;
        r.ch2 = (cur_channels > 2 && wsum != 0) ? 8'(acc[2] / wsum) : '0;
        last = (out_row + 1 >= h) && (out_col + 1 >= w);
        r.frame_end = last;
        r.zero_weight = (wsum == 0);
        expected_pixels.push_back(r);
        if (last)
        begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            frame_in_done = 0;
        end
        else
        begin
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            failed = 1;
        end
    endfunction

    initial clk = 0;
    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 0; req_type <= 0;
            sample_ch0 <= 0; sample_ch1 <= 0; sample_ch2 <= 0;
            tx_gap = 0; tx_burst = 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_pixel('{req_type, sample_ch0, sample_ch1, sample_ch2});
                n_accepted++;
                if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 8);
            end
            if (!(push && full))
            begin
                if (tx_gap > 0)
                begin
                    push <= 0;
                    tx_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    pixel_item_t it;
                    it = pending_items.pop_front();
                    req_type <= it.flush;
                    sample_ch0 <= it.s0; sample_ch1 <= it.s1; sample_ch2 <= it.s2;
                    push <= 1;
                end
                else
                    push <= 0;
            end
        end
    end

    // long receiver hold-off so the input side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_stall <= 0;
            stall_used <= 0;
        end
        else if (rx_stall != 0)
            rx_stall <= rx_stall - 1;
        else if (!stall_used && n_accepted >= 60)
        begin
            rx_stall <= 600;
            stall_used <= 1;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 0;
            rx_gap = 0; rx_burst = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: result with none expected, actual %0d %0d %0d %0d %0d",
                             $time, filtered_ch0, filtered_ch1, filtered_ch2,
                             frame_end, zero_weight);
                    failed = 1;
                end
                else
                begin
                    result_t e;
                    e = expected_pixels.pop_front();
                    check_field("filtered_ch0", int'(e.ch0), int'(filtered_ch0));
                    check_field("filtered_ch1", int'(e.ch1), int'(filtered_ch1));
                    check_field("filtered_ch2", int'(e.ch2), int'(filtered_ch2));
                    check_field("frame_end", int'(e.frame_end), int'(frame_end));
                    check_field("zero_weight", int'(e.zero_weight), int'(zero_weight));
                end
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (rx_stall != 0)
                pop <= 0;
            else if (rx_gap > 0)
            begin
                pop <= 0;
                rx_gap--;
            end
            else
                pop <= 1;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [WP_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            CFG_WEIGHTS:  cur_weights = val;
            CFG_WIDTH:    cur_width = val[FW_W-1:0];
            CFG_HEIGHT:   cur_height = val[FH_W-1:0];
            CFG_CHANNELS: cur_channels = val[CC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [WP_W-1:0] wts, int w, int h, int ch);
        write_reg(CFG_WEIGHTS, wts);
        write_reg(CFG_WIDTH, WP_W'(w));
        write_reg(CFG_HEIGHT, WP_W'(h));
        write_reg(CFG_CHANNELS, WP_W'(ch));
    endtask

    // waits until the block has drained, with slack for non-emitting items
    task automatic drain();
        while (pending_items.size() != 0 || push || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [WP_W-1:0] rand_weights();
        logic [WP_W-1:0] v;
        int unsigned p;
        for (int k = 0; k < N_WEIGHTS; k++)
        begin
            p = $urandom_range(0, 7);
            v[WT_W*k +: WT_W] = (p < 2) ? 7'd0 : (p == 2) ? 7'd127 : 7'($urandom);
        end
        return v;
    endfunction

    function automatic void add_item(bit fl, int s0, int s1, int s2);
        pixel_item_t it;
        it.flush = fl;
        it.s0 = CH_W'(s0); it.s1 = CH_W'(s1); it.s2 = CH_W'(s2);
        pending_items.push_back(it);
    endfunction

    // one frame of pixels, stray early flushes when noise is set, then the trailing flush run
    function automatic void add_frame(int noise);
        int unsigned w, h, n;
        w = width_eff();
        h = height_eff();
        for (int i = 0; i < w * h; i++)
        begin
            if (noise && $urandom_range(0, 29) == 0)
                add_item(1, $urandom, $urandom, $urandom);
            add_item(0, $urandom, $urandom, $urandom);
        end
        n = (w * h < w + 1) ? w * h : w + 1;
        for (int i = 0; i < n; i++)
            add_item(noise ? ($urandom_range(0, 3) != 0) : 1,
                     $urandom, $urandom, $urandom);
    endfunction

    initial
    begin
        rst_n = 0;
        cfg_valid = 0; cfg_index = CFG_WEIGHTS; cfg_data = '0;
        cur_weights = '0; cur_width = 1024; cur_height = 1024; cur_channels = 3;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0; frame_in_done = 0;
        n_accepted = 0; failed = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: sample extremes, early flush, pixel used as flush
        setup({N_WEIGHTS{7'd127}}, 3, 2, 3);
        add_item(1, 0, 0, 0);
        add_item(0, 0, 0, 0);
        add_item(0, 255, 255, 255);
        add_item(0, 255, 0, 255);
        add_item(0, 0, 255, 0);
        add_item(0, 170, 85, 1);
        add_item(0, 128, 127, 254);
        add_item(1, 0, 0, 0);
        add_item(0, 255, 255, 255);
        add_item(1, 0, 0, 0);
        add_item(1, 0, 0, 0);
        drain();
        // all weights zero, zero width and height taken as one
        setup('0, 0, 0, 3);
        add_item(0, 200, 100, 50);
        add_item(1, 0, 0, 0);
        // only the top-left tap weighted: first row and column see a zero sum
        drain();
        setup(WP_W'(7'd127), 2, 2, 0);
        add_frame(0);
        drain();
        setup(rand_weights(), 4, 3, 1);
        add_frame(0);
        drain();
        setup(rand_weights(), 3, 3, 2);
        add_frame(1);
        drain();

        // random phases of small frames
        while (n_accepted < 370)
        begin
            setup(rand_weights(), $urandom_range(1, 12), $urandom_range(1, 8),
                  $urandom_range(0, 3));
            repeat ($urandom_range(1, 3)) add_frame(1);
            drain();
        end

        if (!failed)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/nwc_pkg.sv
sv/nwc_fifo.sv
sv/nwc_front.sv
sv/nwc_back.sv
sv/normalized_window_convolution.sv
sim/tb.sv
